>>> rtl/icp_pkg.sv
// Shared types, constants and matcher helpers for the interval command parser.
// No dependencies; every other file of the block but icp_cmd_if imports this package.
`timescale 1ns / 1ps
`default_nettype none

package icp_pkg;

  // Default configuration values for the top-level parameters
  localparam int BufferSizeDef      = 128;
  localparam int DefaultIntervalDef = 1000;

  // Field widths and interval limits
  localparam int          IntervalW    = 13;
  localparam int          AccumW       = 16;
  localparam logic [12:0] MIN_INTERVAL = 13'd50;
  localparam logic [12:0] MAX_INTERVAL = 13'd5000;

  // Special characters
  localparam logic [7:0] CH_CLOSE_BRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE       = 8'h22;
  localparam logic [7:0] CH_MINUS       = 8'h2D;
  localparam logic [7:0] CH_PLUS        = 8'h2B;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_TAB         = 8'h09;
  localparam logic [7:0] CH_CR          = 8'h0D;
  localparam logic [7:0] CH_ZERO        = 8'h30;
  localparam logic [7:0] CH_NINE        = 8'h39;
  localparam logic [7:0] CH_NUL         = 8'h00;

  // Number parser phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SPACE  = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Quoted interval command token and key "value":
  localparam int TokenLen = 14;
  localparam int KeyLen   = 8;

  localparam logic [7:0] TOKEN_PAT [TokenLen] = '{
    8'h22, "S", "E", "T", "_", "I", "N", "T", "E", "R", "V", "A", "L", 8'h22
  };
  localparam logic [7:0] KEY_PAT [KeyLen] = '{
    8'h22, "v", "a", "l", "u", "e", 8'h22, ":"
  };

  // Per-frame scanner state
  typedef struct packed {
    logic [3:0]           token_pos;
    logic                 token_seen;
    logic [2:0]           key_pos;
    logic [1:0]           phase;
    logic                 negative;
    logic [IntervalW-1:0] accum;
    logic                 overflow;
    logic                 zero_seen;
  } scan_state_t;

  localparam scan_state_t SCAN_CLEAR = '{
    token_pos: 4'd0, token_seen: 1'b0, key_pos: 3'd0, phase: PH_IDLE,
    negative: 1'b0, accum: '0, overflow: 1'b0, zero_seen: 1'b0
  };

  // Token matcher: only the opening quote can restart a partial match
  function automatic logic [3:0] token_step(input logic [3:0] pos, input logic [7:0] c);
    logic [3:0] res;
    if (c == TOKEN_PAT[pos]) begin
      res = pos + 4'd1;
    end else if (c == CH_QUOTE) begin
      res = 4'd1;
    end else begin
      res = 4'd0;
    end
    return res;
  endfunction

  // Key matcher: a 'v' that misses the colon falls back to a two-character match
  function automatic logic [3:0] key_step(input logic [2:0] pos, input logic [7:0] c);
    logic [3:0] res;
    if (c == KEY_PAT[pos]) begin
      res = {1'b0, pos} + 4'd1;
    end else if (pos == 3'(KeyLen - 1) && c == KEY_PAT[1]) begin
      res = 4'd2;
    end else if (c == CH_QUOTE) begin
      res = 4'd1;
    end else begin
      res = 4'd0;
    end
    return res;
  endfunction

  // Space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

`default_nettype wire

>>> rtl/icp_cmd_if.sv
// Command byte channel: valid/ready handshake carrying one received byte.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface icp_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/icp_rsp_if.sv
// Acknowledge channel: valid/ready handshake carrying the frame result.
// Depends on icp_pkg for the interval width.
`timescale 1ns / 1ps
`default_nettype none

interface icp_rsp_if
  import icp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 ack;
  logic                 interval_updated;
  logic [IntervalW-1:0] frame_interval;

  modport source (output valid, output ack, output interval_updated, output frame_interval,
                  input ready);
  modport sink   (input valid, input ack, input interval_updated, input frame_interval,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/icp_scan.sv
// Per-byte scanner: token and key matchers plus the atoi-style number reader.
// Purely combinational; depends on icp_pkg for the state struct and helpers.
`timescale 1ns / 1ps
`default_nettype none

module icp_scan
  import icp_pkg::*;
(
  input  wire scan_state_t cur,
  input  wire logic [7:0]  rx_byte,
  output scan_state_t      nxt
);

  logic [3:0]        tpos;
  logic [3:0]        kpos;
  logic              digit_mode;
  logic [AccumW-1:0] prod;

  // Ten times the accumulator plus the digit, as shifts and adds
  assign prod = ({3'b000, cur.accum} << 3) + ({3'b000, cur.accum} << 1)
              + {12'd0, rx_byte[3:0]};

  assign tpos = token_step(cur.token_pos, rx_byte);
  assign kpos = key_step(cur.key_pos, rx_byte);

  always_comb begin
    nxt        = cur;
    digit_mode = 1'b0;
    if (!cur.zero_seen) begin
      if (rx_byte == CH_NUL) begin
        // Stop searching for the rest of the frame
        nxt.zero_seen = 1'b1;
      end else begin
        // Advance the token matcher until the token has been found
        if (!cur.token_seen) begin
          if (tpos == 4'(TokenLen)) begin
            nxt.token_seen = 1'b1;
            nxt.token_pos  = 4'd0;
          end else begin
            nxt.token_pos = tpos;
          end
        end
        // Advance the key matcher, or read the number after the key
        if (cur.phase == PH_IDLE) begin
          if (kpos == 4'(KeyLen)) begin
            nxt.key_pos = 3'd0;
            nxt.phase   = PH_SPACE;
          end else begin
            nxt.key_pos = kpos[2:0];
          end
        end else begin
          if (cur.phase == PH_SPACE) begin
            if (!is_space(rx_byte)) begin
              nxt.phase = PH_DIGITS;
              if (rx_byte == CH_MINUS) begin
                nxt.negative = 1'b1;
              end else if (rx_byte != CH_PLUS) begin
                digit_mode = 1'b1;
              end
            end
          end else if (cur.phase == PH_DIGITS) begin
            digit_mode = 1'b1;
          end
          if (digit_mode) begin
            if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
              // Saturate at the upper limit and mark out of range
              if (cur.overflow || prod > AccumW'(MAX_INTERVAL)) begin
                nxt.overflow = 1'b1;
                nxt.accum    = MAX_INTERVAL;
              end else begin
                nxt.accum = prod[IntervalW-1:0];
              end
            end else begin
              nxt.phase = PH_DONE;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/interval_command_parser_core.sv
// Interval command parser: command bytes stream in one per clock through an input
// register; the per-byte scanner sits between it and a result register, so the
// acknowledge for a closing '}' is offered the cycle after the brace leaves the input
// register. An acknowledge waiting on a stalled result side holds every byte behind
// it. Once a frame holds BUFFER_SIZE-1 bytes, the next byte, even a brace, is dropped
// and matching restarts. A frame that holds the quoted interval command token and a
// "value": key followed by a number in 50..5000 replaces the stored interval (reset
// value DEFAULT_INTERVAL), which every acknowledge reports.
// Depends on icp_pkg, icp_cmd_if, icp_rsp_if and icp_scan.
`timescale 1ns / 1ps
`default_nettype none

module interval_command_parser_core
  import icp_pkg::*;
#(
  parameter int BUFFER_SIZE      = BufferSizeDef,
  parameter int DEFAULT_INTERVAL = DefaultIntervalDef
) (
  input  wire logic clk,
  input  wire logic rst,
  icp_cmd_if.sink   cmd,
  icp_rsp_if.source rsp
);

  localparam int CountW = $clog2(BUFFER_SIZE);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Frame state
  logic [CountW-1:0]    byte_count;
  scan_state_t          scan;
  scan_state_t          scan_next;
  logic [IntervalW-1:0] interval_reg;

  // Result register
  logic                 out_valid;
  logic                 out_updated;
  logic [IntervalW-1:0] out_interval;

  logic advance;
  logic frame_full;
  logic frame_end;
  logic accept_value;

  // Move a request into the frame logic whenever the result slot is free or being taken
  assign advance    = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready  = !s1_valid || advance;
  assign frame_full = byte_count >= CountW'(BUFFER_SIZE - 1);
  assign frame_end  = !frame_full && (s1_byte == CH_CLOSE_BRACE);

  icp_scan u_scan (
    .cur     (scan),
    .rx_byte (s1_byte),
    .nxt     (scan_next)
  );

  // Judge the frame on the state that includes the closing brace
  assign accept_value = scan_next.token_seen && (scan_next.phase != PH_IDLE)
                     && !scan_next.negative && !scan_next.overflow
                     && (scan_next.accum >= MIN_INTERVAL)
                     && (scan_next.accum <= MAX_INTERVAL);

  // Hold the incoming byte
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
    if (cmd.ready && cmd.valid) begin
      s1_byte <= cmd.rx_byte;
    end
  end

  // Update frame state, stored interval and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      scan         <= SCAN_CLEAR;
      interval_reg <= IntervalW'(DEFAULT_INTERVAL);
      out_valid    <= 1'b0;
    end else begin
      // Fill the result slot on a closing brace, clear it once taken
      if (advance && frame_end) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (frame_full) begin
          // Drop the byte and restart matching
          byte_count <= '0;
          scan       <= SCAN_CLEAR;
        end else if (frame_end) begin
          byte_count <= '0;
          scan       <= SCAN_CLEAR;
          if (accept_value) begin
            interval_reg <= scan_next.accum;
          end
        end else begin
          byte_count <= byte_count + CountW'(1);
          scan       <= scan_next;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance && frame_end) begin
      out_updated  <= accept_value;
      out_interval <= accept_value ? scan_next.accum : interval_reg;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.ack              = 1'b1;
  assign rsp.interval_updated = out_updated;
  assign rsp.frame_interval   = out_interval;

`ifndef SYNTHESIS
  a_interval_range: assert property (@(posedge clk) disable iff (rst)
    (interval_reg >= MIN_INTERVAL) && (interval_reg <= MAX_INTERVAL))
    else $error("stored interval out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CountW'(BUFFER_SIZE - 1))
    else $error("frame byte count past buffer limit");

  a_idle_number_clear: assert property (@(posedge clk) disable iff (rst)
    (scan.phase == PH_IDLE) |-> (scan.accum == '0 && !scan.negative && !scan.overflow))
    else $error("number state set before key found");

  a_token_pos_parked: assert property (@(posedge clk) disable iff (rst)
    scan.token_seen |-> (scan.token_pos == 4'd0))
    else $error("token matcher moved after token found");

  a_update_reports: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_updated) |-> (out_interval == interval_reg))
    else $error("reported interval differs from stored interval");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for interval_command_parser_core: feeds command bytes,
// predicts each frame acknowledge in a behavioral parser and compares every field.
// Depends on icp_pkg, icp_cmd_if, icp_rsp_if and the parser RTL.
`timescale 1ns / 1ps

module testbench;
  import icp_pkg::*;

  localparam int BufSize     = BufferSizeDef;
  localparam int DefInterval = DefaultIntervalDef;
  localparam int CycleLimit  = 400000;
  localparam int LongStall   = 400;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic                 ack;
    logic                 updated;
    logic [IntervalW-1:0] interval;
  } frame_ack_t;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   error_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   stall_requests = 0;
  int   stall_served = 0;
  int   bytes_accepted = 0;
  int   acks_predicted = 0;

  frame_ack_t pending_acks[$];
  logic [7:0] frame_bytes[$];

  // Parser prediction state
  logic [7:0]           frame_len;
  logic [3:0]           tok_pos;
  logic                 tok_found;
  logic [3:0]           key_pos;
  logic [1:0]           num_phase;
  logic                 num_neg;
  logic [IntervalW-1:0] num_val;
  logic                 num_ovf;
  logic                 nul_seen;
  logic [IntervalW-1:0] stored_interval;

  icp_cmd_if cmd ();
  icp_rsp_if rsp ();

  interval_command_parser_core #(
    .BUFFER_SIZE      (BufSize),
    .DEFAULT_INTERVAL (DefInterval)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame parser prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_frame_state();
    frame_len = '0;
    tok_pos   = '0;
    tok_found = 1'b0;
    key_pos   = '0;
    num_phase = PH_IDLE;
    num_neg   = 1'b0;
    num_val   = '0;
    num_ovf   = 1'b0;
    nul_seen  = 1'b0;
  endfunction

  // Any mismatch restarts the token, only a quote can reopen it
  function automatic logic [3:0] advance_token(input logic [3:0] pos, input logic [7:0] c);
    logic [3:0] p;
    p = (pos >= 4'(TokenLen)) ? 4'd0 : pos;
    if (p > 0 && c != TOKEN_PAT[p]) p = 4'd0;
    if (c == TOKEN_PAT[p]) p = p + 4'd1;
    return p;
  endfunction

  // A miss at the colon falls back to a one-character match of the key
  function automatic logic [3:0] advance_key(input logic [3:0] pos, input logic [7:0] c);
    logic [3:0] p;
    p = (pos >= 4'(KeyLen)) ? 4'd0 : pos;
    while (p > 0 && c != KEY_PAT[p[2:0]]) p = (p == 4'(KeyLen - 1)) ? 4'd1 : 4'd0;
    if (c == KEY_PAT[p[2:0]]) p = p + 4'd1;
    return p;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Read the value after the key: blanks, optional sign, then digits
  function automatic void read_number_char(input logic [7:0] c);
    int v;
    if (num_phase == PH_SPACE) begin
      if (is_blank(c)) return;
      num_phase = PH_DIGITS;
      if (c == CH_MINUS) begin
        num_neg = 1'b1;
        return;
      end
      if (c == CH_PLUS) return;
    end
    if (num_phase == PH_DIGITS) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        v = int'(num_val) * 10 + int'(c - CH_ZERO);
        if (num_ovf || v > int'(MAX_INTERVAL)) begin
          num_ovf = 1'b1;
          v = int'(MAX_INTERVAL);
        end
        num_val = IntervalW'(v);
      end else begin
        num_phase = PH_DONE;
      end
    end
  endfunction

  function automatic void scan_cmd_char(input logic [7:0] c);
    if (nul_seen) return;
    if (c == CH_NUL) begin
      nul_seen = 1'b1;
      return;
    end
    if (!tok_found) begin
      tok_pos = advance_token(tok_pos, c);
      if (tok_pos == 4'(TokenLen)) begin
        tok_found = 1'b1;
        tok_pos = '0;
      end
    end
    if (num_phase == PH_IDLE) begin
      key_pos = advance_key(key_pos, c);
      if (key_pos == 4'(KeyLen)) begin
        key_pos = '0;
        num_phase = PH_SPACE;
      end
    end else begin
      read_number_char(c);
    end
  endfunction

  // Returns 1 when the byte closes a frame; res then holds the acknowledge
  function automatic bit predict_cmd_byte(input logic [7:0] c, output frame_ack_t res);
    logic upd;
    res = '0;
    if (int'(frame_len) >= BufSize - 1) begin
      clear_frame_state();
      return 1'b0;
    end
    frame_len = frame_len + 8'd1;
    scan_cmd_char(c);
    if (c != CH_CLOSE_BRACE) return 1'b0;
    upd = tok_found && num_phase != PH_IDLE && !num_neg && !num_ovf &&
          num_val >= MIN_INTERVAL && num_val <= MAX_INTERVAL;
    if (upd) stored_interval = num_val;
    clear_frame_state();
    res.ack = 1'b1;
    res.updated = upd;
    res.interval = stored_interval;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Quoted command token as text, built from the matcher pattern
  function automatic string token_text();
    string s;
    s = "";
    for (int i = 0; i < TokenLen; i++) s = $sformatf("%s%c", s, TOKEN_PAT[i]);
    return s;
  endfunction

  // Offer one request after a random gap, predict its result on acceptance
  task automatic send_byte(input logic [7:0] c);
    frame_ack_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.rx_byte <= c;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    bytes_accepted++;
    if (predict_cmd_byte(c, res)) begin
      pending_acks.push_back(res);
      acks_predicted++;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  // Overwrite one of the last n queued bytes with a random character from 'A' to 'z'
  function automatic void corrupt_tail(input int n);
    int idx;
    idx = frame_bytes.size() - 1 - $urandom_range(n - 1);
    frame_bytes[idx] = 8'($urandom_range(8'h7A, 8'h41));
  endfunction

  function automatic void push_token();
    int r;
    string tok;
    tok = token_text();
    r = $urandom_range(99);
    if (r < 70) begin
      push_text(tok);
    end else if (r < 78) begin
      push_text({"\"", tok});
    end else if (r < 84) begin
      push_text({tok.substr(0, 7), tok});
    end else if (r < 92) begin
      push_text(tok);
      corrupt_tail(TokenLen);
    end
  endfunction

  function automatic void push_key();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      push_text("\"value\":");
    end else if (r < 78) begin
      push_text("\"value\"value\":");
    end else if (r < 84) begin
      push_text("\"valu\"value\":");
    end else if (r < 92) begin
      push_text("\"value\":");
      corrupt_tail(KeyLen);
    end
  endfunction

  function automatic void push_number();
    int r;
    int val;
    repeat ($urandom_range(3)) begin
      if ($urandom_range(1)) frame_bytes.push_back(8'h20);
      else frame_bytes.push_back(8'(8'h09 + $urandom_range(4)));
    end
    r = $urandom_range(99);
    if (r < 12) frame_bytes.push_back(CH_PLUS);
    else if (r < 25) frame_bytes.push_back(CH_MINUS);
    if ($urandom_range(9) == 0) frame_bytes.push_back(CH_ZERO);
    r = $urandom_range(99);
    if (r < 55) begin
      val = $urandom_range(5000, 50);
    end else if (r < 70) begin
      case ($urandom_range(4))
        0: val = 0;
        1: val = 49;
        2: val = 50;
        3: val = 5000;
        default: val = 5001;
      endcase
    end else if (r < 92) begin
      val = $urandom_range(99999);
    end else begin
      val = -1;
    end
    if (val >= 0) push_text($sformatf("%0d", val));
    if ($urandom_range(2) == 0) push_text(",\"x\":7");
  endfunction

  // Mostly well-formed command frames with random content, some noise
  task automatic send_random_frame();
    int kind;
    kind = $urandom_range(99);
    frame_bytes.delete();
    if (kind < 10) begin
      repeat ($urandom_range(24, 1)) frame_bytes.push_back(8'($urandom_range(255)));
    end else if (kind < 13) begin
      // overlong frame around the buffer limit
      repeat ($urandom_range(BufSize + 8, BufSize - 8))
        frame_bytes.push_back(8'($urandom_range(8'h7C, 8'h20)));
      frame_bytes.push_back(CH_CLOSE_BRACE);
    end else begin
      if ($urandom_range(1)) push_text("{\"cmd\":");
      if ($urandom_range(4) == 0) begin
        push_key();
        push_number();
        frame_bytes.push_back(8'h2C);
        push_token();
      end else begin
        push_token();
        if ($urandom_range(1)) frame_bytes.push_back(8'h2C);
        push_key();
        push_number();
      end
      if ($urandom_range(24) == 0)
        frame_bytes.insert($urandom_range(frame_bytes.size()), CH_NUL);
      if ($urandom_range(19) == 0)
        frame_bytes[$urandom_range(frame_bytes.size() - 1)] = 8'($urandom_range(255));
      frame_bytes.push_back(CH_CLOSE_BRACE);
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall at random; serve a long hold when one is requested
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        rsp.ready <= 1'b0;
        for (int n = 0; n < LongStall; n++) @(posedge clk);
      end
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each acknowledge with the oldest prediction
  always @(posedge clk) begin : check_acks
    frame_ack_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_acks.size() == 0) begin
        $display("%0t: unexpected acknowledge: expected none, actual ack=%0b upd=%0b ivl=%0d",
                 $time, rsp.ack, rsp.interval_updated, rsp.frame_interval);
        error_count++;
      end else begin
        want = pending_acks.pop_front();
        if (rsp.ack !== want.ack) begin
          $display("%0t: ack mismatch: expected %0b, actual %0b", $time, want.ack, rsp.ack);
          error_count++;
        end
        if (rsp.interval_updated !== want.updated) begin
          $display("%0t: interval_updated mismatch: expected %0b, actual %0b",
                   $time, want.updated, rsp.interval_updated);
          error_count++;
        end
        if (rsp.frame_interval !== want.interval) begin
          $display("%0t: frame_interval mismatch: expected %0d, actual %0d",
                   $time, want.interval, rsp.frame_interval);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Accepted values at both limits, sign and leading blanks
  task automatic test_interval_update();
    send_text({token_text(), "\"value\":50}"});
    send_text({"{\"cmd\":", token_text(), ",\"value\": +5000}"});
    send_text({token_text(), "\"value\":"});
    for (int b = 8'h09; b <= 8'h0D; b++) send_byte(8'(b));
    send_text(" 0777}");
  endtask

  // Values out of range, missing digits, missing token or key
  task automatic test_rejected_values();
    send_text({token_text(), "\"value\":49}"});
    send_text({token_text(), "\"value\":5001}"});
    send_text({token_text(), "\"value\":123456}"});
    send_text({token_text(), "\"value\":-100}"});
    send_text({token_text(), "\"value\":}"});
    send_text("\"value\":100}");
    send_text({token_text(), "}"});
  endtask

  // Partial matches that restart inside the token and the key
  task automatic test_partial_matches();
    string tok;
    tok = token_text();
    send_text({"\"", tok, "\"value\"value\":800}"});
    send_text({"\"value\":2500", tok.substr(0, 7), tok, "}"});
  endtask

  // Nothing after a zero byte is searched, the brace still closes the frame
  task automatic test_zero_byte();
    send_text(token_text());
    send_byte(CH_NUL);
    send_text("\"value\":300}");
    send_byte(8'hFF);
    send_text({token_text(), "\"value\":300"});
    send_byte(CH_NUL);
    send_text("1}");
  endtask

  // Drop the byte after a full frame, even a brace; accept the last fitting one
  task automatic test_full_frame();
    repeat (BufSize - 1) send_byte("a");
    send_byte(CH_CLOSE_BRACE);
    send_text({token_text(), "\"value\":70}"});
    repeat (BufSize - 2) send_byte("x");
    send_byte(CH_CLOSE_BRACE);
  endtask

  // Hold the result side for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stall_requests++;
    repeat (4)
      send_text($sformatf("%s\"value\":%0d}", token_text(), $urandom_range(5200)));
  endtask

  task automatic test_random_frames(input int idle_pct, input int stall_pct);
    int start_bytes;
    int start_acks;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start_bytes = bytes_accepted;
    start_acks = acks_predicted;
    while (bytes_accepted - start_bytes < 40 || acks_predicted - start_acks < 2)
      send_random_frame();
  endtask

  initial begin
    rst <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.rx_byte <= '0;
    clear_frame_state();
    stored_interval = IntervalW'(DefInterval);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_interval_update();
    test_rejected_values();
    test_partial_matches();
    test_zero_byte();
    test_full_frame();
    test_output_backpressure();
    test_random_frames(0, 0);
    test_random_frames(77, 0);
    test_random_frames(0, 77);
    test_random_frames(29, 29);

    cmd.valid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/icp_pkg.sv
rtl/icp_cmd_if.sv
rtl/icp_rsp_if.sv
rtl/icp_scan.sv
rtl/interval_command_parser_core.sv
verif/testbench.sv
